@@ hw/rtl/amna_pkg.sv @@
`default_nettype none

package amna_pkg;

  // Field and port widths.
  localparam int AIR_W      = 16;
  localparam int MACH_W     = 14;
  localparam int ANG_W      = 14;
  localparam int MANG_W     = 16;
  localparam int SLEW_W     = 10;
  localparam int DBAND_W    = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Fixed-point layout.
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int LOG_TABLE_BITS  = 8;
  localparam int TBL_N           = 1 << LOG_TABLE_BITS;
  localparam int TBL_IDX_W       = LOG_TABLE_BITS + 1;
  localparam int MANT_BITS       = 13;
  localparam int INTERP_BITS     = MANT_BITS - LOG_TABLE_BITS;
  localparam int LEAD_W          = 4;
  localparam int LN_W            = 30;
  localparam int LN_S_W          = 33;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ZONE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLEW     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VAL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = CFG_IDX_W'(3);

  // Register reset values.
  localparam logic [ANG_W-1:0]   LOW_ZONE_RST = ANG_W'(5 << ANGLE_FRAC_BITS);
  localparam logic [SLEW_W-1:0]  SLEW_RST     = SLEW_W'(1 << (ANGLE_FRAC_BITS - 1));
  localparam logic [ANG_W-1:0]   MIN_VAL_RST  = ANG_W'(3 << ANGLE_FRAC_BITS);
  localparam logic [DBAND_W-1:0] DEADBAND_RST = DBAND_W'(1 << ANGLE_FRAC_BITS);

  // Polynomial datapath.
  localparam int ACC_W      = 64;
  localparam int HMUL_W     = 52;
  localparam int T_W        = 12;
  localparam int STAGE_W    = 3;
  localparam int POLY_SCALE_STAGE = 2;
  localparam int POLY_LAST_STAGE  = 4;
  localparam int T_MAX      = 4000;
  localparam int SCALE_SH   = 8;
  localparam int ANG_SH     = 32 - ANGLE_FRAC_BITS;
  localparam int ANG_MAX    = (1 << ANG_W) - 1;

  localparam longint P5_10 = 64'sd9765625;
  localparam longint P5_9  = 64'sd1953125;
  localparam longint K5_Q40 = (64'sd52772 * 64'sd1073741824 + 64'sd4882812) / P5_10;
  localparam longint K4_Q40 = (64'sd3338205 * 64'sd1073741824 + 64'sd4882812) / P5_10;
  localparam longint K3_Q40 = (64'sd25509435 * 64'sd1073741824 + 64'sd4882812) / P5_10;
  localparam longint K2_Q40 = (64'sd482328783 * 64'sd2147483648 + 64'sd976562) / P5_9;
  localparam longint K1_Q32 = (64'sd15416690771 * 64'sd4194304 + 64'sd4882812) / P5_10;
  localparam longint K0_Q32 = (64'sd10500510789 * 64'sd4194304 + 64'sd4882812) / P5_10;
  localparam longint ANG_RND = 64'sd1 << (31 - ANGLE_FRAC_BITS);

  localparam longint TOP_ANGLE = ((64'sd23365 << ANGLE_FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam logic [ANG_W-1:0] TOP_ANGLE_SAT =
      (TOP_ANGLE > ANG_MAX) ? ANG_W'(ANG_MAX) : ANG_W'(TOP_ANGLE);

  // Mach ring datapath.
  localparam int MACH_LOW_LIMIT = 1228;
  localparam longint LOW_MACH_ANGLE =
      ((64'sd24814444 << ANGLE_FRAC_BITS) + 64'sd50000) / 64'sd100000;
  localparam logic signed [MANG_W-1:0] LOW_MACH_SAT =
      (LOW_MACH_ANGLE > 32767) ? 16'sh7FFF : MANG_W'(LOW_MACH_ANGLE);
  localparam int DIV_SH       = 30 - ANGLE_FRAC_BITS;
  localparam int MACH_DIVISOR = 4500;
  localparam int POLY_DIVISOR = 10;
  localparam longint HALF_D   = 64'sd2250 << DIV_SH;
  localparam longint MACH_C0  = -(64'sd288384 * 64'sd1073741824);
  localparam int LN_GAIN      = 804160;
  localparam int GAIN_W       = 21;
  localparam int P3_W         = ANG_W + 13;

  // Divide-by-constant unit: one quotient digit a cycle by reciprocal multiply.
  // Each reciprocal is rounded up, which gives the exact quotient for any digit
  // value below the divisor times 2^16.
  localparam int DIVR_W      = 13;
  localparam int DIV_PER_CYC = 16;
  localparam int DIV_STEPS   = ACC_W / DIV_PER_CYC;
  localparam int CNT_W       = 2;
  localparam int REM10_W     = 4;
  localparam int V10_W       = REM10_W + DIV_PER_CYC;
  localparam int RCP10_W     = 20;
  localparam int RCP10_SH    = 23;
  localparam logic [RCP10_W-1:0] RCP10 = RCP10_W'(838861);
  localparam int REM4500_W   = DIVR_W;
  localparam int V4500_W     = REM4500_W + DIV_PER_CYC;
  localparam int RCP4500_W   = 30;
  localparam int RCP4500_SH  = 42;
  localparam logic [RCP4500_W-1:0] RCP4500 = RCP4500_W'(977343670);

  typedef logic [LN_W-1:0] ln_rom_t [TBL_N+1];

  // Unsigned quotient by shift and subtract, used to build the log table.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/N) in Q30 from a truncated atanh series.
  function automatic ln_rom_t ln_rom_build();
    ln_rom_t r;
    longint unsigned y, y2, term, sum;
    for (int i = 0; i <= TBL_N; i++) begin
      y    = udiv64(longint'(i) << 30, longint'(2 * TBL_N + i));
      y2   = (y * y) >> 30;
      term = y;
      sum  = 0;
      for (int k = 0; k < 20; k++) begin
        sum  = sum + udiv64(term, longint'(2 * k + 1));
        term = (term * y2) >> 30;
      end
      r[i] = LN_W'(2 * sum);
    end
    return r;
  endfunction

  localparam ln_rom_t LN_ROM = ln_rom_build();
  localparam logic signed [LN_S_W-1:0] LN2_Q30 = LN_S_W'(LN_ROM[TBL_N]);

  // Horner coefficient added after each stage.
  function automatic logic signed [ACC_W-1:0] poly_coef(input logic [STAGE_W-1:0] stage);
    logic signed [ACC_W-1:0] c;
    case (stage)
      3'd0:    c = -K4_Q40;
      3'd1:    c = -K3_Q40;
      3'd2:    c = K2_Q40;
      3'd3:    c = -K1_Q32;
      3'd4:    c = K0_Q32;
      default: c = '0;
    endcase
    return c;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_DLD, ST_DIV, ST_ADD, ST_SCALE, ST_TGT, ST_NDL,
    ST_LN1, ST_LN2, ST_SUM1, ST_SUM2, ST_ABS, ST_MLD, ST_MDIV, ST_MSAT, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_DLD, OP_DSTEP, OP_ADD, OP_SCALE, OP_TGT, OP_NDL,
    OP_LN1, OP_LN2, OP_SUM1, OP_SUM2, OP_ABS, OP_MLD, OP_MSAT, OP_DONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               div_mach;
    logic [STAGE_W-1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/amna_ifs.sv @@
`default_nettype none

// Input channel: one airspeed and Mach sample per transaction.
interface amna_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [amna_pkg::AIR_W-1:0]  airspeed_tenths;
  logic        [amna_pkg::MACH_W-1:0] mach_q12;
  modport source (output valid, airspeed_tenths, mach_q12, input ready);
  modport sink (input valid, airspeed_tenths, mach_q12, output ready);
endinterface

// Output channel: needle and Mach ring angles.
interface amna_out_if;
  logic                                valid;
  logic                                ready;
  logic        [amna_pkg::ANG_W-1:0]  airspeed_angle;
  logic signed [amna_pkg::MANG_W-1:0] mach_angle;
  modport source (output valid, airspeed_angle, mach_angle, input ready);
  modport sink (input valid, airspeed_angle, mach_angle, output ready);
endinterface

// Configuration write channel.
interface amna_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [amna_pkg::CFG_IDX_W-1:0]     index;
  logic [amna_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/amna_ctrl.sv @@
`default_nettype none

module amna_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  amna_pkg::status_t status_i,
  output amna_pkg::cmd_t    cmd_o
);

  amna_pkg::state_e                  state_q, state_d;
  logic [amna_pkg::STAGE_W-1:0]      stage_q, stage_d;
  logic [amna_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic                              div_last;
  logic                              done_fire;

  assign div_last  = (cnt_q == amna_pkg::CNT_W'(amna_pkg::DIV_STEPS - 1));
  assign done_fire = (state_q == amna_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      amna_pkg::ST_IDLE:  if (in_valid_i) state_d = amna_pkg::ST_MUL;
      amna_pkg::ST_MUL:   state_d = status_i.skip ? amna_pkg::ST_TGT : amna_pkg::ST_DLD;
      amna_pkg::ST_DLD:   state_d = amna_pkg::ST_DIV;
      amna_pkg::ST_DIV:   if (div_last) state_d = amna_pkg::ST_ADD;
      amna_pkg::ST_ADD: begin
        if (stage_q == amna_pkg::STAGE_W'(amna_pkg::POLY_SCALE_STAGE)) begin
          state_d = amna_pkg::ST_SCALE;
        end else if (stage_q == amna_pkg::STAGE_W'(amna_pkg::POLY_LAST_STAGE)) begin
          state_d = amna_pkg::ST_TGT;
        end else begin
          state_d = amna_pkg::ST_MUL;
        end
      end
      amna_pkg::ST_SCALE: state_d = amna_pkg::ST_MUL;
      amna_pkg::ST_TGT:   state_d = amna_pkg::ST_NDL;
      amna_pkg::ST_NDL:   state_d = amna_pkg::ST_LN1;
      amna_pkg::ST_LN1:   state_d = amna_pkg::ST_LN2;
      amna_pkg::ST_LN2:   state_d = amna_pkg::ST_SUM1;
      amna_pkg::ST_SUM1:  state_d = amna_pkg::ST_SUM2;
      amna_pkg::ST_SUM2:  state_d = amna_pkg::ST_ABS;
      amna_pkg::ST_ABS:   state_d = amna_pkg::ST_MLD;
      amna_pkg::ST_MLD:   state_d = amna_pkg::ST_MDIV;
      amna_pkg::ST_MDIV:  if (div_last) state_d = amna_pkg::ST_MSAT;
      amna_pkg::ST_MSAT:  state_d = amna_pkg::ST_DONE;
      amna_pkg::ST_DONE:  if (done_fire) state_d = amna_pkg::ST_IDLE;
      default:            state_d = amna_pkg::ST_IDLE;
    endcase
  end

  // Counters and output valid.
  always_comb begin
    stage_d     = stage_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (done_fire) out_valid_d = 1'b1;
    case (state_q)
      amna_pkg::ST_IDLE:  stage_d = '0;
      amna_pkg::ST_DLD:   cnt_d = '0;
      amna_pkg::ST_MLD:   cnt_d = '0;
      amna_pkg::ST_DIV:   cnt_d = cnt_q + 1'b1;
      amna_pkg::ST_MDIV:  cnt_d = cnt_q + 1'b1;
      amna_pkg::ST_ADD: begin
        if (stage_q != amna_pkg::STAGE_W'(amna_pkg::POLY_SCALE_STAGE) &&
            stage_q != amna_pkg::STAGE_W'(amna_pkg::POLY_LAST_STAGE)) begin
          stage_d = stage_q + 1'b1;
        end
      end
      amna_pkg::ST_SCALE: stage_d = stage_q + 1'b1;
      default: ;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o.op       = amna_pkg::OP_NONE;
    cmd_o.div_mach = (state_q == amna_pkg::ST_MDIV);
    cmd_o.stage    = stage_q;
    case (state_q)
      amna_pkg::ST_IDLE:  if (in_valid_i) cmd_o.op = amna_pkg::OP_LOAD;
      amna_pkg::ST_MUL:   cmd_o.op = status_i.skip ? amna_pkg::OP_NONE : amna_pkg::OP_MUL;
      amna_pkg::ST_DLD:   cmd_o.op = amna_pkg::OP_DLD;
      amna_pkg::ST_DIV:   cmd_o.op = amna_pkg::OP_DSTEP;
      amna_pkg::ST_ADD:   cmd_o.op = amna_pkg::OP_ADD;
      amna_pkg::ST_SCALE: cmd_o.op = amna_pkg::OP_SCALE;
      amna_pkg::ST_TGT:   cmd_o.op = amna_pkg::OP_TGT;
      amna_pkg::ST_NDL:   cmd_o.op = amna_pkg::OP_NDL;
      amna_pkg::ST_LN1:   cmd_o.op = amna_pkg::OP_LN1;
      amna_pkg::ST_LN2:   cmd_o.op = amna_pkg::OP_LN2;
      amna_pkg::ST_SUM1:  cmd_o.op = amna_pkg::OP_SUM1;
      amna_pkg::ST_SUM2:  cmd_o.op = amna_pkg::OP_SUM2;
      amna_pkg::ST_ABS:   cmd_o.op = amna_pkg::OP_ABS;
      amna_pkg::ST_MLD:   cmd_o.op = amna_pkg::OP_MLD;
      amna_pkg::ST_MDIV:  cmd_o.op = amna_pkg::OP_DSTEP;
      amna_pkg::ST_MSAT:  cmd_o.op = amna_pkg::OP_MSAT;
      amna_pkg::ST_DONE:  if (done_fire) cmd_o.op = amna_pkg::OP_DONE;
      default:            cmd_o.op = amna_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == amna_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amna_pkg::ST_IDLE;
      stage_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/amna_dpath.sv @@
`default_nettype none

module amna_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  amna_pkg::cmd_t                      cmd_i,
  output amna_pkg::status_t                   status_o,
  input  logic signed [amna_pkg::AIR_W-1:0]  airspeed_i,
  input  logic        [amna_pkg::MACH_W-1:0] mach_i,
  input  logic                                cfg_we_i,
  input  logic [amna_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [amna_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic        [amna_pkg::ANG_W-1:0]  airspeed_angle_o,
  output logic signed [amna_pkg::MANG_W-1:0] mach_angle_o
);

  localparam int ACC_W = amna_pkg::ACC_W;

  // Configuration registers.
  logic [amna_pkg::ANG_W-1:0]   low_zone_q;
  logic [amna_pkg::SLEW_W-1:0]  slew_q;
  logic [amna_pkg::ANG_W-1:0]   min_val_q;
  logic [amna_pkg::DBAND_W-1:0] deadband_q;

  // Persistent needle and Mach state.
  logic [amna_pkg::ANG_W-1:0]         needle_q, needle_d;
  logic signed [amna_pkg::MANG_W-1:0] held_q;

  // Working registers.
  logic signed [amna_pkg::AIR_W-1:0]  t_q;
  logic [amna_pkg::MACH_W-1:0]        m_q;
  logic signed [ACC_W-1:0]            acc_q, acc_d;
  logic signed [ACC_W-1:0]            prod_q, prod_d;
  logic [ACC_W-1:0]                   dvd_q, dvd_d;
  logic [amna_pkg::DIVR_W-1:0]        rem_q, rem_d;
  logic                               neg_q, neg_d;
  logic [amna_pkg::ANG_W-1:0]         tgt_q, tgt_d;
  logic [amna_pkg::LN_W-1:0]          lo_q, hi_q;
  logic [amna_pkg::INTERP_BITS-1:0]   frac_lo_q;
  logic [amna_pkg::LEAD_W-1:0]        lead_q;
  logic signed [amna_pkg::LN_S_W-1:0] ln_q, ln_d;
  logic [amna_pkg::P3_W-1:0]          p3_q;
  logic signed [amna_pkg::MANG_W-1:0] mraw_q, mraw_d;
  logic [amna_pkg::ANG_W-1:0]         out_air_q;
  logic signed [amna_pkg::MANG_W-1:0] out_mach_q;

  // Combinational helpers.
  logic signed [amna_pkg::HMUL_W-1:0] mul_h;
  logic signed [amna_pkg::T_W:0]      mul_t;
  logic signed [amna_pkg::HMUL_W+amna_pkg::T_W:0] mul_full;
  logic [ACC_W-1:0]                   step_dvd;
  logic [amna_pkg::DIVR_W-1:0]        step_rem;
  logic [amna_pkg::DIV_PER_CYC-1:0]   dig, qdig;
  logic [amna_pkg::V10_W-1:0]         v10;
  logic [amna_pkg::V10_W+amna_pkg::RCP10_W-1:0] p10;
  logic [amna_pkg::V4500_W-1:0]       v4500;
  logic [amna_pkg::V4500_W+amna_pkg::RCP4500_W-1:0] p4500;
  logic signed [ACC_W-1:0]            coef;
  logic signed [ACC_W-1:0]            qv;
  logic [amna_pkg::ANG_W-1:0]         qsat;
  logic [amna_pkg::ANG_W-1:0]         diff;
  logic [amna_pkg::LEAD_W-1:0]        lead;
  logic [amna_pkg::LEAD_W-1:0]        shamt;
  logic [amna_pkg::MANT_BITS+amna_pkg::MACH_W-1:0] norm;
  logic [amna_pkg::LOG_TABLE_BITS-1:0] idx;
  logic [amna_pkg::LN_W-1:0]          dlt;
  logic [amna_pkg::LN_W+amna_pkg::INTERP_BITS-1:0] ip;
  logic signed [amna_pkg::LN_S_W-1:0] eterm;
  logic signed [amna_pkg::GAIN_W+amna_pkg::LN_S_W-1:0] gain_prod;
  logic signed [amna_pkg::MANG_W:0]   mdiff;
  logic [amna_pkg::MANG_W:0]          mabs;
  logic                               keep_held;

  assign status_o.skip = (t_q > amna_pkg::AIR_W'(amna_pkg::T_MAX)) || (t_q <= 0);

  // Horner multiply of the running value by the airspeed.
  always_comb begin
    mul_h    = acc_q[amna_pkg::HMUL_W-1:0];
    mul_t    = $signed({1'b0, t_q[amna_pkg::T_W-1:0]});
    mul_full = mul_h * mul_t;
  end

  // Divide-by-constant unit: one 16-bit quotient digit per cycle, most
  // significant digit first, with the running remainder carried along.
  always_comb begin
    dig   = dvd_q[ACC_W-1 -: amna_pkg::DIV_PER_CYC];
    v10   = {rem_q[amna_pkg::REM10_W-1:0], dig};
    v4500 = {rem_q[amna_pkg::REM4500_W-1:0], dig};
    p10   = v10 * amna_pkg::RCP10;
    p4500 = v4500 * amna_pkg::RCP4500;
    if (cmd_i.div_mach) begin
      qdig     = p4500[amna_pkg::RCP4500_SH +: amna_pkg::DIV_PER_CYC];
      step_rem = amna_pkg::DIVR_W'(v4500 - amna_pkg::V4500_W'(qdig)
                                   * amna_pkg::V4500_W'(amna_pkg::MACH_DIVISOR));
    end else begin
      qdig     = p10[amna_pkg::RCP10_SH +: amna_pkg::DIV_PER_CYC];
      step_rem = amna_pkg::DIVR_W'(v10 - amna_pkg::V10_W'(qdig)
                                   * amna_pkg::V10_W'(amna_pkg::POLY_DIVISOR));
    end
    step_dvd = {dvd_q[ACC_W-amna_pkg::DIV_PER_CYC-1:0], qdig};
  end

  // Target angle from the polynomial value.
  always_comb begin
    coef = amna_pkg::poly_coef(cmd_i.stage);
    qv   = (acc_q + amna_pkg::ANG_RND) >>> amna_pkg::ANG_SH;
    qsat = (qv > amna_pkg::ANG_MAX) ? amna_pkg::ANG_W'(amna_pkg::ANG_MAX)
                                    : qv[amna_pkg::ANG_W-1:0];
    if (t_q > amna_pkg::AIR_W'(amna_pkg::T_MAX)) begin
      tgt_d = amna_pkg::TOP_ANGLE_SAT;
    end else if (t_q <= 0 || acc_q <= 0 || qsat < min_val_q) begin
      tgt_d = '0;
    end else begin
      tgt_d = qsat;
    end
  end

  // Needle slewing in the low zone.
  always_comb begin
    diff     = (tgt_q > needle_q) ? tgt_q - needle_q : needle_q - tgt_q;
    needle_d = tgt_q;
    if (tgt_q < low_zone_q && diff > amna_pkg::ANG_W'(slew_q)) begin
      if (tgt_q > needle_q) begin
        needle_d = needle_q + amna_pkg::ANG_W'(slew_q);
      end else begin
        needle_d = needle_q - amna_pkg::ANG_W'(slew_q);
      end
    end
  end

  // Mantissa normalization for the log table.
  always_comb begin
    lead = '0;
    for (int i = 0; i < amna_pkg::MACH_W; i++) begin
      if (m_q[i]) lead = amna_pkg::LEAD_W'(i);
    end
    shamt = amna_pkg::LEAD_W'(amna_pkg::MANT_BITS) - lead;
    norm  = {{amna_pkg::MANT_BITS{1'b0}}, m_q} << shamt;
    idx   = norm[amna_pkg::MANT_BITS-1:amna_pkg::INTERP_BITS];
  end

  // Interpolated natural log plus the octave term.
  always_comb begin
    dlt = hi_q - lo_q;
    ip  = ({{amna_pkg::INTERP_BITS{1'b0}}, dlt} * {{amna_pkg::LN_W{1'b0}}, frac_lo_q})
          >> amna_pkg::INTERP_BITS;
    case (lead_q)
      4'd10:   eterm = -(amna_pkg::LN2_Q30 <<< 1);
      4'd11:   eterm = -amna_pkg::LN2_Q30;
      4'd13:   eterm = amna_pkg::LN2_Q30;
      default: eterm = '0;
    endcase
    ln_d = $signed(amna_pkg::LN_S_W'(lo_q)) + $signed(amna_pkg::LN_S_W'(ip)) + eterm;
    gain_prod = $signed(amna_pkg::GAIN_W'(amna_pkg::LN_GAIN)) * ln_q;
  end

  // Mach angle saturation and deadband.
  always_comb begin
    if (m_q <= amna_pkg::MACH_W'(amna_pkg::MACH_LOW_LIMIT)) begin
      mraw_d = amna_pkg::LOW_MACH_SAT;
    end else if (!neg_q) begin
      mraw_d = (dvd_q > 64'd32767) ? 16'sh7FFF : $signed(dvd_q[amna_pkg::MANG_W-1:0]);
    end else begin
      mraw_d = (dvd_q > 64'd32768) ? 16'sh8000
                                   : $signed(16'd0 - dvd_q[amna_pkg::MANG_W-1:0]);
    end
    mdiff     = 17'(mraw_q) - 17'(held_q);
    mabs      = mdiff[amna_pkg::MANG_W] ? 17'(-mdiff) : 17'(mdiff);
    keep_held = mabs < 17'(deadband_q);
  end

  // Working register updates per command.
  always_comb begin
    acc_d  = acc_q;
    prod_d = prod_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    case (cmd_i.op)
      amna_pkg::OP_LOAD:  acc_d = amna_pkg::K5_Q40;
      amna_pkg::OP_MUL:   prod_d = mul_full[ACC_W-1:0];
      amna_pkg::OP_DLD: begin
        dvd_d = prod_q[ACC_W-1] ? ACC_W'(-prod_q) : ACC_W'(prod_q);
        neg_d = prod_q[ACC_W-1];
        rem_d = '0;
      end
      amna_pkg::OP_DSTEP: begin
        dvd_d = step_dvd;
        rem_d = step_rem;
      end
      amna_pkg::OP_ADD:   acc_d = neg_q ? coef - $signed(dvd_q) : coef + $signed(dvd_q);
      amna_pkg::OP_SCALE:
        acc_d = (acc_q + (acc_q[ACC_W-1] ? 64'sd255 : 64'sd0)) >>> amna_pkg::SCALE_SH;
      amna_pkg::OP_SUM1:  prod_d = ACC_W'(gain_prod);
      amna_pkg::OP_SUM2:
        acc_d = amna_pkg::MACH_C0 - prod_q
                + $signed({{(ACC_W-amna_pkg::P3_W){1'b0}}, p3_q} << amna_pkg::DIV_SH);
      amna_pkg::OP_ABS: begin
        acc_d = acc_q[ACC_W-1] ? -acc_q : acc_q;
        neg_d = acc_q[ACC_W-1];
      end
      amna_pkg::OP_MLD: begin
        dvd_d = ACC_W'(acc_q + amna_pkg::HALF_D) >> amna_pkg::DIV_SH;
        rem_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    if (cmd_i.op == amna_pkg::OP_LOAD) begin
      t_q <= airspeed_i;
      m_q <= mach_i;
    end
    if (cmd_i.op == amna_pkg::OP_TGT) tgt_q <= tgt_d;
    if (cmd_i.op == amna_pkg::OP_LN1) begin
      lo_q      <= amna_pkg::LN_ROM[{1'b0, idx}];
      hi_q      <= amna_pkg::LN_ROM[amna_pkg::TBL_IDX_W'(idx) + 1'b1];
      frac_lo_q <= norm[amna_pkg::INTERP_BITS-1:0];
      lead_q    <= lead;
    end
    if (cmd_i.op == amna_pkg::OP_LN2) ln_q <= ln_d;
    if (cmd_i.op == amna_pkg::OP_SUM1) p3_q <= amna_pkg::P3_W'(needle_q) * 27'd4500;
    if (cmd_i.op == amna_pkg::OP_MSAT) mraw_q <= mraw_d;
    if (cmd_i.op == amna_pkg::OP_DONE) begin
      out_air_q  <= needle_q;
      out_mach_q <= keep_held ? held_q : mraw_q;
    end
  end

  // Configuration and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_zone_q <= amna_pkg::LOW_ZONE_RST;
      slew_q     <= amna_pkg::SLEW_RST;
      min_val_q  <= amna_pkg::MIN_VAL_RST;
      deadband_q <= amna_pkg::DEADBAND_RST;
      needle_q   <= '0;
      held_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          amna_pkg::REG_LOW_ZONE: low_zone_q <= cfg_data_i[amna_pkg::ANG_W-1:0];
          amna_pkg::REG_SLEW:     slew_q     <= cfg_data_i[amna_pkg::SLEW_W-1:0];
          amna_pkg::REG_MIN_VAL:  min_val_q  <= cfg_data_i[amna_pkg::ANG_W-1:0];
          amna_pkg::REG_DEADBAND: deadband_q <= cfg_data_i[amna_pkg::DBAND_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == amna_pkg::OP_NDL) needle_q <= needle_d;
      if (cmd_i.op == amna_pkg::OP_DONE && !keep_held) held_q <= mraw_q;
    end
  end

  assign airspeed_angle_o = out_air_q;
  assign mach_angle_o     = out_mach_q;

endmodule

`default_nettype wire

@@ hw/rtl/airspeed_mach_needle_angle.sv @@
`default_nettype none

// Channel | Modport | Transaction contents
// in_i    | sink    | airspeed_tenths (s16, 0.1 kt), mach_q12 (u14, Q2.12)
// out_o   | source  | airspeed_angle (u14, 1/64 deg), mach_angle (s16, 1/64 deg)
// cfg_i   | sink    | index (4 bits), data (16 bits); always ready
//
// A sample runs through the polynomial and Mach ring states from acceptance to a
// valid result, and the next sample is taken only after that result is committed;
// an airspeed at or below zero or above 400 knots skips the polynomial. The shared
// divide-by-constant unit, retiring one 16-bit quotient digit a cycle, runs once
// per Horner stage and once for the Mach ring. A result waits in the output
// register while the next sample is taken; a finished sample stalls in its last
// state until that register is free.
// Reset clears the needle, the held Mach angle and the control state, and
// loads the configuration defaults.

module airspeed_mach_needle_angle (
  input  logic       clk_i,
  input  logic       rst_ni,
  amna_in_if.sink    in_i,
  amna_out_if.source out_o,
  amna_cfg_if.sink   cfg_i
);

  amna_pkg::cmd_t    cmd;
  amna_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  amna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  amna_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .airspeed_i       (in_i.airspeed_tenths),
    .mach_i           (in_i.mach_q12),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .airspeed_angle_o (out_o.airspeed_angle),
    .mach_angle_o     (out_o.mach_angle)
  );

  // The block holds off new samples right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("sample accepted while busy");

  // A result is committed only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == amna_pkg::OP_DONE) |-> (!out_o.valid || out_o.ready))
    else $error("result overwrote a pending transaction");

  // Output valid rises only after a result commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.op == amna_pkg::OP_DONE))
    else $error("output valid without a commit");

endmodule

`default_nettype wire
